@@ hdl/wpt_pkg.sv @@
// shared types and constants for the work/pause cycle timer
`default_nettype none
package wpt_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TENTH_W    = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_PRO_MODE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CONCENTRATION = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMER_GEAR   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CUSTOM_MIN   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PRO_WORK     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_PRO_PAUSE    = 3'd5;

  localparam logic [2:0] GEAR_CONT   = 3'd0;
  localparam logic [2:0] GEAR_2H     = 3'd1;
  localparam logic [2:0] GEAR_4H     = 3'd2;
  localparam logic [2:0] GEAR_8H     = 3'd3;
  localparam logic [2:0] GEAR_CUSTOM = 3'd4;

  localparam logic [1:0] CONC_LOW = 2'd0;
  localparam logic [1:0] CONC_MID = 2'd1;

  localparam logic [10:0] CONT_MINUTES = 11'd1440;
  localparam logic [10:0] GEAR_2H_MIN  = 11'd120;
  localparam logic [10:0] GEAR_4H_MIN  = 11'd240;
  localparam logic [10:0] GEAR_8H_MIN  = 11'd480;

  localparam logic [7:0] WORK_SHORT  = 8'd15;
  localparam logic [7:0] WORK_LONG   = 8'd30;
  localparam logic [7:0] PAUSE_LONG  = 8'd180;
  localparam logic [7:0] PAUSE_SHORT = 8'd90;

  localparam logic [16:0] WD_SLACK = 17'd10;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_WORK  = 2'd1,
    PH_PAUSE = 2'd2
  } phase_t;

  typedef struct packed {
    logic        pwr_on;
    logic        enable;
    logic        reload_timer;
    logic        second_tick;
    logic        minute_tick;
    logic [16:0] now_sec;
    logic        event_active;
    logic        full_run_ok;
    logic        rtc_fault;
  } wpt_in_t;

  typedef struct packed {
    logic        pump_on;
    logic        motor_drive;
    logic        fan_on;
    phase_t      phase;
    logic [16:0] remaining_sec;
    logic [10:0] minutes_left;
    logic        pump_fault;
    logic        phase_changed;
    logic        timer_report;
  } wpt_out_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
  } wpt_cfg_wr_t;

  typedef struct packed {
    logic               pump_prev;
    logic [TENTH_W-1:0] tenth;
    logic [16:0]        count;
  } wpt_wd_state_t;

endpackage
`default_nettype wire

@@ hdl/wpt_stream_if.sv @@
// valid/ready channel interface carrying one payload
`default_nettype none
interface wpt_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/wpt_watchdog.sv @@
// pump watchdog: tenth-tick counting and phase overrun check
`default_nettype none
module wpt_watchdog
  import wpt_pkg::*;
#(
  parameter int WORK_LIMIT  = 600,
  parameter int PAUSE_LIMIT = 3600,
  parameter int SUBTICKS    = 10
) (
  input  wire logic          pump_sw,
  input  wire logic [15:0]   work,
  input  wire logic [15:0]   pause,
  input  wire wpt_wd_state_t cur,
  output wpt_wd_state_t      upd,
  output logic               fault
);

  logic [TENTH_W:0] tenth_inc;
  logic [16:0]      lim;
  logic [16:0]      len;
  logic [16:0]      cnt;

  assign tenth_inc = {1'b0, cur.tenth} + {{TENTH_W{1'b0}}, 1'b1};
  assign lim = pump_sw ? 17'(WORK_LIMIT) : 17'(PAUSE_LIMIT);
  assign len = {1'b0, (pump_sw ? work : pause)};

  always_comb begin
    cnt           = cur.count;
    upd.pump_prev = cur.pump_prev;
    upd.tenth     = cur.tenth;
    upd.count     = cur.count;
    fault         = 1'b0;
    if (cur.pump_prev == pump_sw) begin
      upd.tenth = tenth_inc[TENTH_W-1:0];
      if (tenth_inc >= (TENTH_W+1)'(SUBTICKS)) begin
        upd.tenth = '0;
        cnt       = cur.count + 17'd1;
      end
      upd.count = cnt;
      if (cnt >= lim) begin
        upd.count = lim + 17'd1;
        fault     = 1'b1;
      end else if (cnt >= len + WD_SLACK) begin
        upd.count = len + WD_SLACK + 17'd1;
        fault     = 1'b1;
      end
    end else begin
      upd.pump_prev = pump_sw;
      upd.count     = '0;
      upd.tenth     = '0;
    end
  end

endmodule
`default_nettype wire

@@ hdl/wpt_core.sv @@
// configuration registers, timer state and single-tick update logic
`default_nettype none
module wpt_core
  import wpt_pkg::*;
#(
  parameter int WORK_LIMIT  = 600,
  parameter int PAUSE_LIMIT = 3600,
  parameter int SUBTICKS    = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire wpt_cfg_wr_t cfg,
  input  wire logic        step,
  input  wire wpt_in_t     item,
  output wpt_out_t         res
);

  // configuration
  logic        pro_mode_r, pro_mode_nxt;
  logic [1:0]  conc_r, conc_nxt;
  logic [2:0]  gear_r, gear_nxt;
  logic [10:0] custom_r, custom_nxt;
  logic [15:0] pro_work_r, pro_work_nxt;
  logic [15:0] pro_pause_r, pro_pause_nxt;

  // tick state
  logic [7:0]    cycle_r, cycle_nxt;
  logic [10:0]   countdown_r, countdown_nxt;
  logic [2:0]    last_gear_r, last_gear_nxt;
  logic          latch_r, latch_nxt;
  logic [16:0]   start_r, start_nxt;
  logic          start_valid_r, start_valid_nxt;
  logic [31:0]   last_times_r, last_times_nxt;
  wpt_wd_state_t wd_r, wd_nxt;
  logic [16:0]   held_r, held_nxt;
  phase_t        prev_phase_r, prev_phase_nxt;
  logic [1:0]    prev_conc_r, prev_conc_nxt;
  logic          pump_r, pump_nxt;
  logic          fan_r, fan_nxt;
  logic          fault_r, fault_nxt;

  logic          latch_a;
  logic          en;
  logic [2:0]    gear_step;
  logic [10:0]   cd_a;
  logic [7:0]    cc_a;
  logic [7:0]    cc_inc;
  logic [7:0]    work8;
  logic [7:0]    pause8;
  logic [7:0]    total8;
  logic [16:0]   sa;
  logic [17:0]   end_w;
  logic [18:0]   end_p;
  logic [31:0]   times;
  phase_t        phase;
  logic          pchg;
  logic          rep;
  logic          wd_run;
  logic [15:0]   wd_work;
  logic [15:0]   wd_pause;
  logic [16:0]   wd_cnt_in;
  wpt_wd_state_t wd_cur;
  wpt_wd_state_t wd_upd;
  logic          wd_fault;

  assign work8  = (conc_r == CONC_LOW) ? WORK_SHORT : WORK_LONG;
  assign pause8 = (conc_r == CONC_LOW || conc_r == CONC_MID) ? PAUSE_LONG : PAUSE_SHORT;
  assign total8 = work8 + pause8;
  assign sa     = start_valid_r ? start_r : item.now_sec;
  assign end_w  = {1'b0, sa} + {2'b0, pro_work_r};
  assign end_p  = {1'b0, end_w} + {3'b0, pro_pause_r};
  assign times  = {pro_pause_r, pro_work_r};
  assign cc_inc = cc_a + 8'd1;

  always_comb begin
    latch_a         = item.enable ? latch_r : 1'b0;
    latch_nxt       = latch_a;
    en              = item.enable & ~latch_a;
    gear_step       = gear_r;
    cd_a            = countdown_r;
    cc_a            = cycle_r;
    cycle_nxt       = cycle_r;
    last_gear_nxt   = last_gear_r;
    start_nxt       = start_r;
    start_valid_nxt = start_valid_r;
    last_times_nxt  = last_times_r;
    held_nxt        = held_r;
    prev_phase_nxt  = prev_phase_r;
    prev_conc_nxt   = prev_conc_r;
    pump_nxt        = pump_r;
    fan_nxt         = fan_r;
    phase           = prev_phase_r;
    pchg            = 1'b0;
    rep             = 1'b0;
    wd_run          = 1'b0;
    wd_work         = '0;
    wd_pause        = '0;
    wd_cnt_in       = wd_r.count;
    if (item.pwr_on) begin
      if (!pro_mode_r) begin
        start_valid_nxt = 1'b0;
        if (!en) begin
          pump_nxt = 1'b0;
          fan_nxt  = 1'b0;
          cc_a     = '0;
          cd_a     = '0;
        end else if (gear_r == GEAR_CONT) begin
          cd_a = CONT_MINUTES;
        end else begin
          if (gear_r != last_gear_r || item.reload_timer) begin
            last_gear_nxt = gear_r;
            case (gear_r)
              GEAR_2H:     cd_a = GEAR_2H_MIN;
              GEAR_4H:     cd_a = GEAR_4H_MIN;
              GEAR_8H:     cd_a = GEAR_8H_MIN;
              GEAR_CUSTOM: cd_a = custom_r;
              default:     cd_a = countdown_r;
            endcase
          end
          if (item.minute_tick) begin
            rep = 1'b1;
            if (cd_a != '0) begin
              cd_a = cd_a - 11'd1;
            end else begin
              gear_step = GEAR_CONT;
              latch_nxt = 1'b1;
            end
          end
        end
        cycle_nxt = cc_a;
        if (cd_a != '0) begin
          if (cc_a < work8) begin
            pump_nxt = 1'b1;
            phase    = PH_WORK;
            held_nxt = {9'b0, 8'(work8 - cc_a)};
          end else begin
            pump_nxt = 1'b0;
            phase    = PH_PAUSE;
            held_nxt = (cc_a < total8) ? {9'b0, 8'(total8 - cc_a)} : '0;
          end
          if (item.second_tick) begin
            cycle_nxt = (cc_inc >= total8) ? '0 : cc_inc;
          end
          wd_run   = 1'b1;
          wd_work  = {8'b0, work8};
          wd_pause = {8'b0, pause8};
        end
      end else begin
        gear_step = GEAR_CONT;
        cycle_nxt = '0;
        if (!en || !item.full_run_ok || !item.event_active) begin
          pump_nxt        = 1'b0;
          fan_nxt         = 1'b0;
          start_valid_nxt = 1'b0;
          phase           = PH_STOP;
        end else begin
          start_valid_nxt = 1'b1;
          start_nxt       = sa;
          phase           = PH_PAUSE;
          if (!start_valid_r) begin
            wd_cnt_in = '0;
          end
          if (item.now_sec < sa) begin
            start_nxt = item.now_sec;
          end else if ({1'b0, item.now_sec} < end_w) begin
            held_nxt = 17'(end_w - {1'b0, item.now_sec});
            phase    = PH_WORK;
          end else if ({2'b0, item.now_sec} < end_p) begin
            held_nxt = 17'(end_p - {2'b0, item.now_sec});
          end else begin
            start_nxt = item.now_sec;
          end
          pump_nxt = (phase == PH_WORK);
          fan_nxt  = (phase == PH_WORK);
          if (times != last_times_r) begin
            last_times_nxt = times;
            wd_cnt_in      = '0;
          end
          wd_run   = 1'b1;
          wd_work  = pro_work_r;
          wd_pause = pro_pause_r;
        end
      end
      if (phase != prev_phase_r) begin
        prev_phase_nxt = phase;
        pchg           = 1'b1;
      end
      if (conc_r != prev_conc_r) begin
        prev_conc_nxt = conc_r;
        rep           = 1'b1;
      end
    end else begin
      pump_nxt        = 1'b0;
      fan_nxt         = 1'b0;
      start_valid_nxt = 1'b0;
    end
  end

  assign countdown_nxt = cd_a;

  assign wd_cur.pump_prev = wd_r.pump_prev;
  assign wd_cur.tenth     = wd_r.tenth;
  assign wd_cur.count     = wd_cnt_in;

  wpt_watchdog #(
    .WORK_LIMIT  (WORK_LIMIT),
    .PAUSE_LIMIT (PAUSE_LIMIT),
    .SUBTICKS    (SUBTICKS)
  ) u_watchdog (
    .pump_sw (pump_nxt),
    .work    (wd_work),
    .pause   (wd_pause),
    .cur     (wd_cur),
    .upd     (wd_upd),
    .fault   (wd_fault)
  );

  assign wd_nxt    = wd_run ? wd_upd : wd_r;
  assign fault_nxt = wd_run ? wd_fault : fault_r;

  // config writes are to happen only while idle, never meeting a step; the block does not enforce it
  always_comb begin
    pro_mode_nxt  = pro_mode_r;
    conc_nxt      = conc_r;
    gear_nxt      = step ? gear_step : gear_r;
    custom_nxt    = custom_r;
    pro_work_nxt  = pro_work_r;
    pro_pause_nxt = pro_pause_r;
    if (cfg.we) begin
      case (cfg.addr)
        REG_PRO_MODE:      pro_mode_nxt  = cfg.data[0];
        REG_CONCENTRATION: conc_nxt      = cfg.data[1:0];
        REG_TIMER_GEAR:    gear_nxt      = cfg.data[2:0];
        REG_CUSTOM_MIN:    custom_nxt    = cfg.data[10:0];
        REG_PRO_WORK:      pro_work_nxt  = cfg.data;
        REG_PRO_PAUSE:     pro_pause_nxt = cfg.data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pro_mode_r  <= 1'b1;
      conc_r      <= '0;
      gear_r      <= GEAR_CONT;
      custom_r    <= '0;
      pro_work_r  <= '0;
      pro_pause_r <= '0;
    end else begin
      pro_mode_r  <= pro_mode_nxt;
      conc_r      <= conc_nxt;
      gear_r      <= gear_nxt;
      custom_r    <= custom_nxt;
      pro_work_r  <= pro_work_nxt;
      pro_pause_r <= pro_pause_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_r       <= '0;
      countdown_r   <= '0;
      last_gear_r   <= '0;
      latch_r       <= 1'b0;
      start_r       <= '0;
      start_valid_r <= 1'b0;
      last_times_r  <= '0;
      wd_r          <= '0;
      held_r        <= '0;
      prev_phase_r  <= PH_STOP;
      prev_conc_r   <= '0;
      pump_r        <= 1'b0;
      fan_r         <= 1'b0;
      fault_r       <= 1'b0;
    end else if (step) begin
      cycle_r       <= cycle_nxt;
      countdown_r   <= countdown_nxt;
      last_gear_r   <= last_gear_nxt;
      latch_r       <= latch_nxt;
      start_r       <= start_nxt;
      start_valid_r <= start_valid_nxt;
      last_times_r  <= last_times_nxt;
      wd_r          <= wd_nxt;
      held_r        <= held_nxt;
      prev_phase_r  <= prev_phase_nxt;
      prev_conc_r   <= prev_conc_nxt;
      pump_r        <= pump_nxt;
      fan_r         <= fan_nxt;
      fault_r       <= fault_nxt;
    end
  end

  always_comb begin
    res.pump_on       = pump_nxt;
    res.motor_drive   = pump_nxt & ~fault_nxt & ~item.rtc_fault;
    res.fan_on        = fan_nxt;
    res.phase         = phase;
    res.remaining_sec = held_nxt;
    res.minutes_left  = cd_a;
    res.pump_fault    = fault_nxt;
    res.phase_changed = pchg;
    res.timer_report  = rep;
  end

endmodule
`default_nettype wire

@@ hdl/work_pause_cycle_timer_with_watchdog.sv @@
// Work/pause pump cycle timer with minute countdown and pump watchdog.
// Each input transaction is one control tick and produces exactly one result
// transaction. A tick lands in an input register, the whole state update runs
// in one pass of shallow logic into the result register, so the block takes
// one tick per clock while the sink keeps ready high, and a result is offered
// from the result register once its tick has left the input register. While
// a finished result waits for the sink the input register holds at most one
// more tick and input ready then stays low until the sink takes the result.
// Configuration writes take effect on the next clock and are expected only
// while no tick is in flight. In professional mode and on countdown expiry
// the block itself returns the timer gear register to continuous.
`default_nettype none
module work_pause_cycle_timer_with_watchdog
  import wpt_pkg::*;
#(
  parameter int WORK_LIMIT  = 600,
  parameter int PAUSE_LIMIT = 3600,
  parameter int SUBTICKS    = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  wpt_stream_if.sink                 in_ch,
  wpt_stream_if.source               out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  wpt_in_t     in_r, in_nxt;
  logic        in_v_r, in_v_nxt;
  wpt_out_t    out_r, out_nxt;
  logic        out_v_r, out_v_nxt;
  logic        advance;
  logic        in_take;
  wpt_cfg_wr_t cfg;
  wpt_out_t    res;

  assign advance      = in_v_r & (~out_v_r | out_ch.ready);
  assign in_ch.ready  = ~in_v_r | advance;
  assign in_take      = in_ch.valid & in_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  assign cfg.we   = cfg_we;
  assign cfg.addr = cfg_addr;
  assign cfg.data = cfg_wdata;

  wpt_core #(
    .WORK_LIMIT  (WORK_LIMIT),
    .PAUSE_LIMIT (PAUSE_LIMIT),
    .SUBTICKS    (SUBTICKS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (advance),
    .item  (in_r),
    .res   (res)
  );

  always_comb begin
    in_nxt    = in_take ? in_ch.data : in_r;
    in_v_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_v_r);
    out_nxt   = advance ? res : out_r;
    out_v_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    out_r <= out_nxt;
  end

  a_motor_needs_pump: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!out_r.motor_drive || out_r.pump_on))
    else $error("motor drive without pump request");

  a_fault_blocks_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.pump_fault |-> !out_r.motor_drive)
    else $error("motor driven while pump fault is set");

  a_stalled_tick_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(in_r))
    else $error("stalled tick lost from input register");

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("processed tick produced no result");

endmodule
`default_nettype wire

@@ test/tb.sv @@
// self-checking testbench for the work/pause cycle timer with pump watchdog
module tb;
  import wpt_pkg::*;

  localparam int WD_WORK_LIMIT  = 600;
  localparam int WD_PAUSE_LIMIT = 3600;
  localparam int WD_SUBTICKS    = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_TICKS    = 125;

  localparam logic       MODE_SIMPLE = 1'b0;
  localparam logic       MODE_PRO    = 1'b1;
  localparam logic [1:0] CONC_HIGH   = 2'd2;
  localparam logic [1:0] CONC_SPARE  = 2'd3;
  localparam logic [2:0] GEAR_SPARE  = 3'd5;
  localparam logic [2:0] GEAR_TOP    = 3'd7;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wpt_stream_if #(.T(wpt_in_t))  in_if ();
  wpt_stream_if #(.T(wpt_out_t)) out_if ();

  work_pause_cycle_timer_with_watchdog #(
    .WORK_LIMIT(WD_WORK_LIMIT),
    .PAUSE_LIMIT(WD_PAUSE_LIMIT),
    .SUBTICKS(WD_SUBTICKS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  wpt_in_t  pending_ticks[$];
  wpt_out_t due_results[$];
  wpt_out_t got_want;
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_req;
  logic [16:0] rtc_now;

  // configuration mirror
  logic        r_pro;
  logic [1:0]  r_conc;
  logic [2:0]  r_gear;
  logic [10:0] r_custom;
  logic [15:0] r_work;
  logic [15:0] r_pause;

  // timer state mirror
  logic [7:0]  cycle_cnt;
  logic [10:0] cd_min;
  logic [2:0]  gear_seen;
  logic        expired;
  logic [16:0] start_s;
  logic        start_ok;
  logic [31:0] times_seen;
  logic        wd_pump_prev;
  logic [3:0]  wd_tenth;
  logic [16:0] wd_secs;
  logic [16:0] rem_hold;
  phase_t      phase_hold;
  logic [1:0]  conc_seen;
  logic        pump_q;
  logic        fan_q;
  logic        fault_q;

  always #5 clk = ~clk;

  function automatic void clear_model();
    r_pro = MODE_PRO; r_conc = CONC_LOW; r_gear = GEAR_CONT; r_custom = '0;
    r_work = '0; r_pause = '0;
    cycle_cnt = '0; cd_min = '0; gear_seen = '0; expired = 1'b0;
    start_s = '0; start_ok = 1'b0; times_seen = '0; wd_pump_prev = 1'b0;
    wd_tenth = '0; wd_secs = '0; rem_hold = '0; phase_hold = PH_STOP;
    conc_seen = '0; pump_q = 1'b0; fan_q = 1'b0; fault_q = 1'b0;
  endfunction

  function automatic bit wd_step(int unsigned wk, int unsigned ps);
    int unsigned lim, len;
    if (wd_pump_prev == pump_q) begin
      lim = pump_q ? WD_WORK_LIMIT : WD_PAUSE_LIMIT;
      len = pump_q ? wk : ps;
      wd_tenth = wd_tenth + 1'b1;
      if (wd_tenth >= WD_SUBTICKS) begin
        wd_tenth = '0;
        wd_secs = wd_secs + 1'b1;
      end
      if (wd_secs >= lim) begin
        wd_secs = 17'(lim + 1);
        return 1'b1;
      end
      if (wd_secs >= len + WD_SLACK) begin
        wd_secs = 17'(len + WD_SLACK + 1);
        return 1'b1;
      end
    end else begin
      wd_pump_prev = pump_q;
      wd_secs = '0;
      wd_tenth = '0;
    end
    return 1'b0;
  endfunction

  function automatic wpt_out_t timer_tick(wpt_in_t t);
    wpt_out_t r;
    phase_t ph;
    logic en, chg, rep;
    int unsigned wk, ps, tot, s, now;
    ph = phase_hold;
    chg = 1'b0;
    rep = 1'b0;
    now = 32'(t.now_sec);
    if (!t.enable) expired = 1'b0;
    en = t.enable && !expired;
    if (t.pwr_on) begin
      if (r_pro == MODE_SIMPLE) begin
        start_ok = 1'b0;
        if (!en) begin
          pump_q = 1'b0; fan_q = 1'b0; cycle_cnt = '0; cd_min = '0;
        end else if (r_gear == GEAR_CONT) begin
          cd_min = CONT_MINUTES;
        end else begin
          if (r_gear != gear_seen || t.reload_timer) begin
            gear_seen = r_gear;
            case (r_gear)
              GEAR_2H: cd_min = GEAR_2H_MIN;
              GEAR_4H: cd_min = GEAR_4H_MIN;
              GEAR_8H: cd_min = GEAR_8H_MIN;
              GEAR_CUSTOM: cd_min = r_custom;
              default: ;
            endcase
          end
          if (t.minute_tick) begin
            rep = 1'b1;
            if (cd_min != 0) cd_min = cd_min - 1'b1;
            else begin
              r_gear = GEAR_CONT;
              expired = 1'b1;
            end
          end
        end
        if (cd_min != 0) begin
          wk = (r_conc == CONC_LOW) ? 32'(WORK_SHORT) : 32'(WORK_LONG);
          ps = (r_conc <= CONC_MID) ? 32'(PAUSE_LONG) : 32'(PAUSE_SHORT);
          tot = wk + ps;
          if (cycle_cnt < wk) begin
            pump_q = 1'b1; ph = PH_WORK; rem_hold = 17'(wk - cycle_cnt);
          end else begin
            pump_q = 1'b0; ph = PH_PAUSE;
            rem_hold = (cycle_cnt < tot) ? 17'(tot - cycle_cnt) : '0;
          end
          if (t.second_tick) begin
            cycle_cnt = cycle_cnt + 1'b1;
            if (cycle_cnt >= tot) cycle_cnt = '0;
          end
          fault_q = wd_step(wk, ps);
        end
      end else begin
        r_gear = GEAR_CONT;
        cycle_cnt = '0;
        if (!en || !t.full_run_ok || !t.event_active) begin
          pump_q = 1'b0; fan_q = 1'b0; start_ok = 1'b0; ph = PH_STOP;
        end else begin
          wk = 32'(r_work);
          ps = 32'(r_pause);
          if (!start_ok) begin
            wd_secs = '0; start_s = t.now_sec; start_ok = 1'b1;
          end
          ph = PH_PAUSE;
          s = 32'(start_s);
          if (now < s) start_s = t.now_sec;
          else if (now < s + wk) begin
            rem_hold = 17'(s + wk - now);
            ph = PH_WORK;
          end else if (now < s + wk + ps) rem_hold = 17'(s + wk + ps - now);
          else start_s = t.now_sec;
          if (ph == PH_WORK) begin
            pump_q = 1'b1; fan_q = 1'b1; fault_q = 1'b0;
          end else begin
            pump_q = 1'b0; fan_q = 1'b0;
          end
          if ({r_pause, r_work} != times_seen) begin
            times_seen = {r_pause, r_work};
            wd_secs = '0;
          end
          fault_q = wd_step(wk, ps);
        end
      end
      if (ph != phase_hold) begin
        phase_hold = ph;
        chg = 1'b1;
      end
      if (r_conc != conc_seen) begin
        conc_seen = r_conc;
        rep = 1'b1;
      end
    end else begin
      pump_q = 1'b0; fan_q = 1'b0; start_ok = 1'b0;
    end
    r.pump_on = pump_q;
    r.motor_drive = pump_q && !fault_q && !t.rtc_fault;
    r.fan_on = fan_q;
    r.phase = ph;
    r.remaining_sec = rem_hold;
    r.minutes_left = cd_min;
    r.pump_fault = fault_q;
    r.phase_changed = chg;
    r.timer_report = rep;
    return r;
  endfunction

  function automatic wpt_in_t mk_tick(int unsigned pw, int unsigned en, int unsigned rl,
                                      int unsigned sec, int unsigned mn, int unsigned now,
                                      int unsigned ev, int unsigned full, int unsigned rf);
    wpt_in_t t;
    t.pwr_on = 1'(pw); t.enable = 1'(en); t.reload_timer = 1'(rl);
    t.second_tick = 1'(sec); t.minute_tick = 1'(mn); t.now_sec = 17'(now);
    t.event_active = 1'(ev); t.full_run_ok = 1'(full); t.rtc_fault = 1'(rf);
    return t;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) due_results.push_back(timer_tick(in_if.data));
      if (!in_if.valid || in_if.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data <= pending_ticks.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result ready with long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing expected, actual %p", $time,
                 out_if.data);
      end else begin
        got_want = due_results.pop_front();
        check_field("pump_on", 32'(got_want.pump_on), 32'(out_if.data.pump_on));
        check_field("motor_drive", 32'(got_want.motor_drive),
                    32'(out_if.data.motor_drive));
        check_field("fan_on", 32'(got_want.fan_on), 32'(out_if.data.fan_on));
        check_field("phase", 32'(got_want.phase), 32'(out_if.data.phase));
        check_field("remaining_sec", 32'(got_want.remaining_sec),
                    32'(out_if.data.remaining_sec));
        check_field("minutes_left", 32'(got_want.minutes_left),
                    32'(out_if.data.minutes_left));
        check_field("pump_fault", 32'(got_want.pump_fault), 32'(out_if.data.pump_fault));
        check_field("phase_changed", 32'(got_want.phase_changed),
                    32'(out_if.data.phase_changed));
        check_field("timer_report", 32'(got_want.timer_report),
                    32'(out_if.data.timer_report));
      end
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    case (idx)
      REG_PRO_MODE: r_pro = 1'(val);
      REG_CONCENTRATION: r_conc = 2'(val);
      REG_TIMER_GEAR: r_gear = 3'(val);
      REG_CUSTOM_MIN: r_custom = 11'(val);
      REG_PRO_WORK: r_work = 16'(val);
      REG_PRO_PAUSE: r_pause = 16'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(logic pro, logic [1:0] conc, logic [2:0] gear,
                            int unsigned custom, int unsigned work, int unsigned pause);
    write_reg(REG_PRO_MODE, 32'(pro));
    write_reg(REG_CONCENTRATION, 32'(conc));
    write_reg(REG_TIMER_GEAR, 32'(gear));
    write_reg(REG_CUSTOM_MIN, custom);
    write_reg(REG_PRO_WORK, work);
    write_reg(REG_PRO_PAUSE, pause);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || due_results.size() != 0 || in_if.valid);
    repeat (4) @(posedge clk);
  endtask

  // mostly a running clock with random flags, some fully random noise
  task automatic gen_ticks(int n, int sec_pct, int min_pct);
    wpt_in_t t;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        t = mk_tick($urandom_range(1), $urandom_range(1), $urandom_range(1),
                    $urandom_range(1), $urandom_range(1), $urandom_range(86399),
                    $urandom_range(1), $urandom_range(1), $urandom_range(1));
      end else begin
        t.second_tick = ($urandom_range(99) < sec_pct);
        if ($urandom_range(199) == 0)
          rtc_now = 17'($urandom_range(1) ? 86390 + $urandom_range(9)
                                          : $urandom_range(86399));
        else if (t.second_tick)
          rtc_now = (rtc_now == 86399) ? '0 : rtc_now + 1'b1;
        t.now_sec = rtc_now;
        t.minute_tick = ($urandom_range(99) < min_pct);
        t.pwr_on = ($urandom_range(99) < 97);
        t.enable = ($urandom_range(99) < 95);
        t.reload_timer = ($urandom_range(99) < 3);
        t.event_active = ($urandom_range(99) < 92);
        t.full_run_ok = ($urandom_range(99) < 95);
        t.rtc_fault = ($urandom_range(99) < 3);
      end
      pending_ticks.push_back(t);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    errors = 0;
    hold_req = 1'b0;
    hold_left = 0;
    rtc_now = 86340;
    send_idle_pct = 27;
    recv_idle_pct = 49;
    clear_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // professional mode after reset, zero work and pause
    pending_ticks.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 0, 0, 0, 1, 1, 0));
    wait_idle();

    // simple mode: one custom minute runs out and latches off
    set_config(MODE_SIMPLE, CONC_LOW, GEAR_CUSTOM, 1, 0, 0);
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 1, 10, 0, 0, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 1, 11, 0, 0, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 0, 12, 0, 0, 0));
    pending_ticks.push_back(mk_tick(1, 0, 0, 0, 0, 12, 0, 0, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 0, 13, 0, 0, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 0, 14, 0, 0, 1));
    pending_ticks.push_back(mk_tick(0, 1, 0, 1, 1, 15, 1, 1, 0));
    wait_idle();

    // unused gear and concentration codes
    set_config(MODE_SIMPLE, CONC_SPARE, GEAR_SPARE, 1440, 0, 0);
    pending_ticks.push_back(mk_tick(1, 1, 1, 1, 1, 16, 0, 0, 0));
    pending_ticks.push_back(mk_tick(1, 1, 1, 1, 0, 17, 0, 0, 0));
    wait_idle();

    // professional schedule across midnight and a full cycle
    set_config(MODE_PRO, CONC_LOW, GEAR_CONT, 0, 3, 2);
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 0, 86398, 1, 1, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 0, 86399, 1, 1, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 1, 0, 1, 1, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 0, 1, 1, 1, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 0, 4, 1, 1, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 0, 5, 1, 1, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 0, 6, 0, 1, 0));
    pending_ticks.push_back(mk_tick(1, 1, 0, 1, 0, 7, 1, 0, 0));
    pending_ticks.push_back(mk_tick(1, 1, 1, 1, 1, 86399, 1, 1, 1));
    wait_idle();

    set_config(MODE_SIMPLE, CONC_LOW, GEAR_CUSTOM, 3, 10, 20);
    gen_ticks(PHASE_TICKS, 40, 6);
    wait_idle();

    set_config(MODE_SIMPLE, CONC_MID, GEAR_2H, 1440, 10, 20);
    gen_ticks(PHASE_TICKS, 60, 4);
    hold_req = 1'b1;
    wait_idle();

    set_config(MODE_PRO, CONC_MID, GEAR_4H, 7, 5, 4);
    gen_ticks(PHASE_TICKS, 50, 3);
    wait_idle();

    send_idle_pct = 49;
    recv_idle_pct = 27;
    set_config(MODE_SIMPLE, CONC_HIGH, GEAR_CONT, 2, 5, 4);
    gen_ticks(PHASE_TICKS, 3, 2);
    wait_idle();

    // sender stops until every result is back, then resumes
    set_config(MODE_PRO, CONC_HIGH, GEAR_CONT, 2, 0, 0);
    gen_ticks(PHASE_TICKS / 2, 50, 3);
    wait_idle();
    set_config(MODE_PRO, CONC_HIGH, GEAR_CONT, 2, 65535, 65535);
    gen_ticks(PHASE_TICKS - PHASE_TICKS / 2, 50, 3);
    wait_idle();

    set_config(MODE_SIMPLE, CONC_SPARE, GEAR_8H, 0, 30, 30);
    gen_ticks(PHASE_TICKS, 30, 5);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(MODE_PRO, CONC_LOW, GEAR_2H, 0, 2, 1);
    gen_ticks(PHASE_TICKS, 2, 3);
    wait_idle();

    set_config(MODE_SIMPLE, CONC_LOW, GEAR_CUSTOM, 0, 2, 1);
    gen_ticks(PHASE_TICKS, 30, 5);
    wait_idle();

    set_config(MODE_SIMPLE, CONC_HIGH, GEAR_TOP, 1440, 2, 1);
    gen_ticks(PHASE_TICKS, 30, 3);
    wait_idle();

    repeat (10) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
